// ----- design/header_sync_packet_deframer_top_assert.svh -----
// ---------------------------------------------------------------------------
// header_sync_packet_deframer_top assertion macros
// assertion macros used by the deframer top, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef HEADER_SYNC_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define HEADER_SYNC_PACKET_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define HSPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, checked out of reset
`define HSPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define HSPD_ASSERT_NOW(lbl, ante, cons)
`define HSPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/hspd_pkg.sv -----
// ---------------------------------------------------------------------------
// hspd_pkg
// types and constants shared by the packet deframer modules
// ---------------------------------------------------------------------------
package hspd_pkg;

  localparam int unsigned PacketBytes = 10;
  localparam int unsigned CountW      = 4;
  localparam int unsigned SumW        = 12;
  localparam int unsigned PayloadN    = PacketBytes - 2;
  localparam int unsigned PayIdxW     = $clog2(PayloadN);

  localparam logic [7:0] HeaderReset = 8'h20;
  localparam logic [7:0] MaskReset   = 8'h40;

  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_HEADER_VALUE  = 2'd0,
    CFG_CHECKSUM_MASK = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] checksum_mask;
  } cfg_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [31:0] second_word;
    logic [31:0] first_word;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic              packet_open;
    logic              res_fire;
  } status_t;

endpackage

// ----- design/hspd_framer.sv -----
// ---------------------------------------------------------------------------
// hspd_framer
// input byte register, framing state and checksum, one byte per cycle unless a result is held back
// ---------------------------------------------------------------------------
module hspd_framer (
  input  logic              clk,
  input  logic              rst,
  input  hspd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              res_ready,
  output logic              res_valid,
  output hspd_pkg::result_t res,
  output hspd_pkg::status_t status
);
  import hspd_pkg::*;

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic [CountW-1:0]   byte_count;
  logic                packet_open;
  logic [SumW-1:0]     running_sum;
  logic [7:0]          payload_bytes [PayloadN];

  logic                hdr_hit;
  logic                open_eff;
  logic [CountW-1:0]   pos;
  logic                last_pos;
  logic                make_res;
  logic                s1_fire;
  logic [7:0]          expect_byte;

  assign hdr_hit  = (s1_byte == cfg.header_value) && !packet_open;
  assign open_eff = packet_open || hdr_hit;

  always_comb begin
    if (hdr_hit || (byte_count >= CountW'(PacketBytes))) begin
      pos = '0;
    end else begin
      pos = byte_count;
    end
  end

  assign last_pos    = (pos == CountW'(PacketBytes - 1));
  assign make_res    = last_pos && open_eff;
  assign s1_fire     = s1_valid && (!make_res || res_ready);
  assign in_ready    = !s1_valid || s1_fire;
  assign res_valid   = s1_fire && make_res;
  assign expect_byte = running_sum[7:0] & cfg.checksum_mask;

  assign res.first_word  = {payload_bytes[3], payload_bytes[2],
                            payload_bytes[1], payload_bytes[0]};
  assign res.second_word = {payload_bytes[7], payload_bytes[6],
                            payload_bytes[5], payload_bytes[4]};
  assign res.checksum_ok = (expect_byte == s1_byte);

  assign status.byte_count  = byte_count;
  assign status.packet_open = packet_open;
  assign status.res_fire    = res_valid;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      packet_open <= 1'b0;
      running_sum <= '0;
    end else if (s1_fire) begin
      if (pos == '0) begin
        running_sum <= SumW'(s1_byte);
      end else if (!last_pos) begin
        running_sum <= running_sum + SumW'(s1_byte);
      end
      if (last_pos) begin
        byte_count  <= '0;
        packet_open <= 1'b0;
      end else begin
        byte_count  <= pos + CountW'(1);
        packet_open <= open_eff;
      end
    end
  end

  // payload bytes, positions one to eight
  always_ff @(posedge clk) begin
    if (s1_fire && (pos != '0) && !last_pos) begin
      payload_bytes[PayIdxW'(pos - CountW'(1))] <= s1_byte;
    end
  end

endmodule

// ----- design/hspd_out_reg.sv -----
// ---------------------------------------------------------------------------
// hspd_out_reg
// result register between the framer and the master stream
// ---------------------------------------------------------------------------
module hspd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  hspd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output hspd_pkg::result_t out_res
);
  import hspd_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- design/header_sync_packet_deframer_top.sv -----
// ---------------------------------------------------------------------------
// header_sync_packet_deframer_top
// fixed-length packet deframer with header sync and masked-sum check
// ---------------------------------------------------------------------------
// usage
//   slave stream carries one received byte per item in s_tdata
//   a header byte seen while no packet is open starts a ten-byte packet
//   bytes are counted modulo ten, open or not; a header byte while closed restarts the count
//   after the tenth byte of an open packet one item leaves the master stream:
//   bytes 1-4 and 5-8 as little-endian words, and checksum_ok in m_tuser
//   failing packets still produce an item, with checksum_ok low
//   config: cfg_we writes cfg_data to register cfg_index
//     (0 header value, 1 checksum mask); other indices are ignored
// timing
//   one byte per cycle sustained while the output register can take results;
//   the last byte of a packet passes the input register, and its result the
//   output register, before the result shows on m_tvalid
//   a stalled master holds its result; the input register keeps taking
//   bytes until a second finished packet needs the output register
// reset
//   rst (synchronous) clears count, open flag, sum and both valids, and
//   sets header 0x20 and mask 0x40
// ---------------------------------------------------------------------------
module header_sync_packet_deframer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,  // [7:0] rx_byte
  // master stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [63:0]                          m_tdata,  // [31:0] first_word, [63:32] second_word
  output logic                                 m_tuser,  // [0] checksum_ok
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [hspd_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data
);
  import hspd_pkg::*;

  `include "header_sync_packet_deframer_top_assert.svh"

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  status_t status;
  logic    res_valid;
  logic    res_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value  <= HeaderReset;
      cfg.checksum_mask <= MaskReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_VALUE:  cfg.header_value  <= cfg_data;
        CFG_CHECKSUM_MASK: cfg.checksum_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte register, framing state and check
  hspd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // result register toward the master side
  hspd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.second_word, out_res.first_word};
  assign m_tuser = out_res.checksum_ok;

  // count stays inside the packet
  `HSPD_ASSERT_NOW(a_count_range, 1'b1, status.byte_count < CountW'(PacketBytes))
  // a result closes the packet and restarts the count
  `HSPD_ASSERT_NEXT(a_res_closes, status.res_fire, !status.packet_open)
  `HSPD_ASSERT_NEXT(a_res_count, status.res_fire, status.byte_count == '0)
  // a result always lands in the output register
  `HSPD_ASSERT_NEXT(a_res_lands, status.res_fire, m_tvalid)

endmodule
